[hdl/rcp_pkg.sv]
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types, widths, constants and arithmetic helpers of the rectangle
// contact point block.
// ----------------------------------------------------------------------------
package rcp_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int ANG_W  = 16;
	localparam int HALF_W = 31;
	localparam int POS_W  = 32;
	localparam int NRM_W  = 16;
	localparam int XW     = 27;   // sine, cosine and matrix entries, Q.24
	localparam int ZW     = 28;   // residual angle, Q.24
	localparam int PROD_W = HALF_W + 1 + XW;
	localparam int ACC_W  = 62;
	localparam int VW     = ACC_W - 24;

	localparam logic signed [ZW-1:0] Q24_PI      = 28'sd52707179;
	localparam logic signed [ZW-1:0] Q24_HALF_PI = 28'sd26353589;

	localparam logic [23:0] ATAN_Q24 [24] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
		24'd1047214,  24'd524117,  24'd262123,  24'd131069,
		24'd65536,    24'd32768,   24'd16384,   24'd8192,
		24'd4096,     24'd2048,    24'd1024,    24'd512,
		24'd256,      24'd128,     24'd64,      24'd32,
		24'd16,       24'd8,       24'd4,       24'd2
	};

	typedef struct packed {
		logic [HALF_W-1:0]       hx;
		logic [HALF_W-1:0]       hy;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
	} item_t;

	typedef struct packed {
		logic signed [XW-1:0] r00;
		logic signed [XW-1:0] r01;
		logic signed [XW-1:0] r02;
		logic signed [XW-1:0] r10;
		logic signed [XW-1:0] r11;
		logic signed [XW-1:0] r12;
		logic signed [XW-1:0] r20;
		logic signed [XW-1:0] r21;
		logic signed [XW-1:0] r22;
	} rmat_t;

	function automatic int clamp_steps(input int n);
		int r;
		r = n;
		if (r < 8) r = 8;
		if (r > 24) r = 24;
		return r;
	endfunction

	function automatic logic signed [XW-1:0] cordic_gain(input int n);
		logic signed [XW-1:0] g;
		if (n <= 8) g = 27'sd10188117;
		else if (n == 9) g = 27'sd10188040;
		else if (n == 10) g = 27'sd10188020;
		else if (n == 11) g = 27'sd10188015;
		else g = 27'sd10188014;
		return g;
	endfunction

	// Q.24 product, rounded half up
	function automatic logic signed [XW-1:0] mul24(input logic signed [XW-1:0] a,
		input logic signed [XW-1:0] b);
		logic signed [2*XW-1:0] p;
		p = a * b + (54'sd1 <<< 23);
		return p[24+XW-1:24];
	endfunction

endpackage

[hdl/rcp_cordic.sv]
// ----------------------------------------------------------------------------
// rcp_cordic
// Three parallel CORDIC pipelines (roll, pitch, yaw), one rotation step per
// stage, with the rectangle item carried alongside.
// ----------------------------------------------------------------------------
module rcp_cordic #(
	parameter int CORDIC_STEPS = rcp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  rcp_pkg::item_t                    in_item,
	input  logic signed [rcp_pkg::ANG_W-1:0]  in_ang [3],
	output logic                              out_valid,
	output rcp_pkg::item_t                    out_item,
	output logic signed [rcp_pkg::XW-1:0]     out_sin [3],
	output logic signed [rcp_pkg::XW-1:0]     out_cos [3]
);
	localparam int N  = rcp_pkg::clamp_steps(CORDIC_STEPS);
	localparam int XW = rcp_pkg::XW;
	localparam int ZW = rcp_pkg::ZW;

	logic                 v_s    [N+1];
	rcp_pkg::item_t       item_s [N+1];
	logic signed [XW-1:0] x_s    [N+1][3];
	logic signed [XW-1:0] y_s    [N+1][3];
	logic signed [ZW-1:0] z_s    [N+1][3];
	logic                 flip_s [N+1][3];

	// stage 0: widen to Q.24 and fold into +-pi/2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_pre
		logic signed [ZW-1:0] zw;
		assign zw = {{(ZW-rcp_pkg::ANG_W-11){in_ang[a][rcp_pkg::ANG_W-1]}}, in_ang[a], 11'b0};
		always_ff @(posedge clk) begin
			x_s[0][a] <= rcp_pkg::cordic_gain(N);
			y_s[0][a] <= '0;
			if (zw > rcp_pkg::Q24_HALF_PI) begin
				z_s[0][a]    <= zw - rcp_pkg::Q24_PI;
				flip_s[0][a] <= 1'b1;
			end else if (zw < -rcp_pkg::Q24_HALF_PI) begin
				z_s[0][a]    <= zw + rcp_pkg::Q24_PI;
				flip_s[0][a] <= 1'b1;
			end else begin
				z_s[0][a]    <= zw;
				flip_s[0][a] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s[0] <= in_item;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			item_s[i+1] <= item_s[i];
		end
		for (genvar a = 0; a < 3; a++) begin : g_ang
			logic signed [ZW-1:0] at;
			assign at = $signed({{(ZW-24){1'b0}}, rcp_pkg::ATAN_Q24[i]});
			always_ff @(posedge clk) begin
				flip_s[i+1][a] <= flip_s[i][a];
				if (!z_s[i][a][ZW-1]) begin
					x_s[i+1][a] <= x_s[i][a] - (y_s[i][a] >>> i);
					y_s[i+1][a] <= y_s[i][a] + (x_s[i][a] >>> i);
					z_s[i+1][a] <= z_s[i][a] - at;
				end else begin
					x_s[i+1][a] <= x_s[i][a] + (y_s[i][a] >>> i);
					y_s[i+1][a] <= y_s[i][a] - (x_s[i][a] >>> i);
					z_s[i+1][a] <= z_s[i][a] + at;
				end
			end
		end
	end

	// output stage: undo the fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		out_item <= item_s[N];
	end

	for (genvar a = 0; a < 3; a++) begin : g_out
		always_ff @(posedge clk) begin
			out_sin[a] <= flip_s[N][a] ? -y_s[N][a] : y_s[N][a];
			out_cos[a] <= flip_s[N][a] ? -x_s[N][a] : x_s[N][a];
		end
	end

endmodule

[hdl/rcp_matrix.sv]
// ----------------------------------------------------------------------------
// rcp_matrix
// Two stage rotation matrix builder: pair products, then the mixed terms.
// ----------------------------------------------------------------------------
module rcp_matrix (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  rcp_pkg::item_t                in_item,
	input  logic signed [rcp_pkg::XW-1:0] in_sin [3],
	input  logic signed [rcp_pkg::XW-1:0] in_cos [3],
	output logic                          out_valid,
	output rcp_pkg::item_t                out_item,
	output rcp_pkg::rmat_t                out_rmat
);
	localparam int XW = rcp_pkg::XW;

	logic                 v_s1;
	rcp_pkg::item_t       item_s1;
	logic signed [XW-1:0] cc_s1, cs_s1, sc_s1, ss_s1, sj_s1;
	logic signed [XW-1:0] r00_s1, r10_s1, r21_s1, r22_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	// index 0 roll (i), 1 pitch (j), 2 yaw (k)
	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		cc_s1   <= rcp_pkg::mul24(in_cos[0], in_cos[2]);
		cs_s1   <= rcp_pkg::mul24(in_cos[0], in_sin[2]);
		sc_s1   <= rcp_pkg::mul24(in_sin[0], in_cos[2]);
		ss_s1   <= rcp_pkg::mul24(in_sin[0], in_sin[2]);
		r00_s1  <= rcp_pkg::mul24(in_cos[1], in_cos[2]);
		r10_s1  <= rcp_pkg::mul24(in_cos[1], in_sin[2]);
		r21_s1  <= rcp_pkg::mul24(in_cos[1], in_sin[0]);
		r22_s1  <= rcp_pkg::mul24(in_cos[1], in_cos[0]);
		sj_s1   <= in_sin[1];
	end

	always_ff @(posedge clk) begin
		out_item     <= item_s1;
		out_rmat.r00 <= r00_s1;
		out_rmat.r01 <= rcp_pkg::mul24(sj_s1, sc_s1) - cs_s1;
		out_rmat.r02 <= rcp_pkg::mul24(sj_s1, cc_s1) + ss_s1;
		out_rmat.r10 <= r10_s1;
		out_rmat.r11 <= rcp_pkg::mul24(sj_s1, ss_s1) + cc_s1;
		out_rmat.r12 <= rcp_pkg::mul24(sj_s1, cs_s1) - sc_s1;
		out_rmat.r20 <= -sj_s1;
		out_rmat.r21 <= r21_s1;
		out_rmat.r22 <= r22_s1;
	end

endmodule

[hdl/rcp_corner.sv]
// ----------------------------------------------------------------------------
// rcp_corner
// Scales the matrix columns by the half sizes once per item, then walks the
// four corners, one per cycle, with rounding and saturation.
// ----------------------------------------------------------------------------
module rcp_corner #(
	parameter int COORD_WIDTH = rcp_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  rcp_pkg::item_t                   in_item,
	input  rcp_pkg::rmat_t                   in_rmat,
	output logic                             strobe,
	output logic [1:0]                       corner_index,
	output logic signed [COORD_WIDTH-1:0]    point_x,
	output logic signed [COORD_WIDTH-1:0]    point_y,
	output logic signed [COORD_WIDTH-1:0]    point_z,
	output logic signed [rcp_pkg::NRM_W-1:0] normal_x,
	output logic signed [rcp_pkg::NRM_W-1:0] normal_y,
	output logic signed [rcp_pkg::NRM_W-1:0] normal_z,
	output logic                             last_corner
);
	localparam int XW     = rcp_pkg::XW;
	localparam int PROD_W = rcp_pkg::PROD_W;
	localparam int ACC_W  = rcp_pkg::ACC_W;
	localparam int VW     = rcp_pkg::VW;
	localparam int NRM_W  = rcp_pkg::NRM_W;
	localparam int HALF_W_LOC = rcp_pkg::HALF_W + 1;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	function automatic logic signed [NRM_W-1:0] to_normal(input logic signed [XW-1:0] r);
		logic signed [XW-1:0] t;
		logic signed [XW-11:0] v;
		t = r + 27'sd512;
		v = t[XW-1:10];
		if (v > 17'sd16384) v = 17'sd16384;
		if (v < -17'sd16384) v = -17'sd16384;
		return v[NRM_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] pos_acc(input logic signed [rcp_pkg::POS_W-1:0] p);
		return {{(ACC_W-rcp_pkg::POS_W-24){p[rcp_pkg::POS_W-1]}}, p, 24'b0};
	endfunction

	function automatic logic signed [ACC_W-1:0] prod_ext(input logic signed [PROD_W-1:0] p);
		return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] round_sat(
		input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		logic signed [63:0]      v;
		t = acc + (62'sd1 <<< 23);
		v = {{(64-VW){t[ACC_W-1]}}, t[ACC_W-1:24]};
		if (v > SAT_HI) v = SAT_HI;
		if (v < SAT_LO) v = SAT_LO;
		return v[COORD_WIDTH-1:0];
	endfunction

	// product stage
	logic                     v_s1;
	logic signed [PROD_W-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [rcp_pkg::POS_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [NRM_W-1:0]  nx_s1, ny_s1, nz_s1;
	logic signed [HALF_W_LOC-1:0] hx_e, hy_e;

	assign hx_e = $signed({1'b0, in_item.hx});
	assign hy_e = $signed({1'b0, in_item.hy});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= hx_e * in_rmat.r00;
		ay_s1 <= hx_e * in_rmat.r10;
		az_s1 <= hx_e * in_rmat.r20;
		bx_s1 <= hy_e * in_rmat.r01;
		by_s1 <= hy_e * in_rmat.r11;
		bz_s1 <= hy_e * in_rmat.r21;
		px_s1 <= in_item.px;
		py_s1 <= in_item.py;
		pz_s1 <= in_item.pz;
		nx_s1 <= to_normal(in_rmat.r02);
		ny_s1 <= to_normal(in_rmat.r12);
		nz_s1 <= to_normal(in_rmat.r22);
	end

	// corner walker: busy in the top keeps a new item from arriving before the last one's four corners are walked
	logic                     act_q;
	logic [1:0]               k_q;
	logic signed [ACC_W-1:0]  px_q, py_q, pz_q, ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [NRM_W-1:0]  nx_q, ny_q, nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q   <= '0;
		end else if (v_s1) begin
			act_q <= 1'b1;
			k_q   <= '0;
		end else if (act_q) begin
			k_q <= k_q + 2'd1;
			if (k_q == 2'd3) act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			px_q <= pos_acc(px_s1);
			py_q <= pos_acc(py_s1);
			pz_q <= pos_acc(pz_s1);
			ax_q <= prod_ext(ax_s1);
			ay_q <= prod_ext(ay_s1);
			az_q <= prod_ext(az_s1);
			bx_q <= prod_ext(bx_s1);
			by_q <= prod_ext(by_s1);
			bz_q <= prod_ext(bz_s1);
			nx_q <= nx_s1;
			ny_q <= ny_s1;
			nz_q <= nz_s1;
		end
	end

	// corner sums: x sign negative for corners 2,3, y sign for corners 1,2
	logic                    neg_x, neg_y;
	logic                    v_s2;
	logic [1:0]              k_s2;
	logic signed [ACC_W-1:0] sx_s2, sy_s2, sz_s2;
	logic signed [NRM_W-1:0] nx_s2, ny_s2, nz_s2;

	assign neg_x = k_q[1];
	assign neg_y = k_q[1] ^ k_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		k_s2  <= k_q;
		sx_s2 <= px_q + (neg_x ? -ax_q : ax_q) + (neg_y ? -bx_q : bx_q);
		sy_s2 <= py_q + (neg_x ? -ay_q : ay_q) + (neg_y ? -by_q : by_q);
		sz_s2 <= pz_q + (neg_x ? -az_q : az_q) + (neg_y ? -bz_q : bz_q);
		nx_s2 <= nx_q;
		ny_s2 <= ny_q;
		nz_s2 <= nz_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		corner_index <= k_s2;
		last_corner  <= (k_s2 == 2'd3);
		point_x      <= round_sat(sx_s2);
		point_y      <= round_sat(sy_s2);
		point_z      <= round_sat(sz_s2);
		normal_x     <= nx_s2;
		normal_y     <= ny_s2;
		normal_z     <= nz_s2;
	end

endmodule

[hdl/rectangle_contact_points_top.sv]
// ----------------------------------------------------------------------------
// rectangle_contact_points_top
// Rotates and places the four corners of a rectangle from roll, pitch and yaw.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each item gives
// four corner results on consecutive cycles, marked by strobe, corner 3 with
// last_corner set; the receiver cannot stall them. busy rises after each
// accepted item and holds off the next one for as long as the result port,
// at one corner per cycle, takes to give out its four corners. The path to
// strobe runs through the fold stage and one stage per rotation step in the
// CORDIC pipeline, its output register, two matrix stages, a scaling stage,
// the corner walker, the corner sum stage and the output register.
module rectangle_contact_points_top #(
	parameter int COORD_WIDTH  = rcp_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = rcp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rcp_pkg::HALF_W-1:0]         half_size_x,
	input  logic [rcp_pkg::HALF_W-1:0]         half_size_y,
	input  logic signed [rcp_pkg::POS_W-1:0]   pos_x,
	input  logic signed [rcp_pkg::POS_W-1:0]   pos_y,
	input  logic signed [rcp_pkg::POS_W-1:0]   pos_z,
	input  logic signed [rcp_pkg::ANG_W-1:0]   roll_angle,
	input  logic signed [rcp_pkg::ANG_W-1:0]   pitch_angle,
	input  logic signed [rcp_pkg::ANG_W-1:0]   yaw_angle,
	output logic                               strobe,
	output logic [1:0]                         corner_index,
	output logic signed [COORD_WIDTH-1:0]      point_x,
	output logic signed [COORD_WIDTH-1:0]      point_y,
	output logic signed [COORD_WIDTH-1:0]      point_z,
	output logic signed [rcp_pkg::NRM_W-1:0]   normal_x,
	output logic signed [rcp_pkg::NRM_W-1:0]   normal_y,
	output logic signed [rcp_pkg::NRM_W-1:0]   normal_z,
	output logic                               last_corner
);
	logic                                accept;
	logic [1:0]                          gap_q;
	rcp_pkg::item_t                      item;
	logic signed [rcp_pkg::ANG_W-1:0]    ang [3];
	logic                                cor_valid, mat_valid;
	rcp_pkg::item_t                      cor_item, mat_item;
	logic signed [rcp_pkg::XW-1:0]       cor_sin [3];
	logic signed [rcp_pkg::XW-1:0]       cor_cos [3];
	rcp_pkg::rmat_t                      mat_rmat;

	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	// spaces transactions so that the corner walker finishes each item's four corners before the next arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	assign item.hx = half_size_x;
	assign item.hy = half_size_y;
	assign item.px = pos_x;
	assign item.py = pos_y;
	assign item.pz = pos_z;
	assign ang[0]  = roll_angle;
	assign ang[1]  = pitch_angle;
	assign ang[2]  = yaw_angle;

	rcp_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_item  (item),
		.in_ang   (ang),
		.out_valid(cor_valid),
		.out_item (cor_item),
		.out_sin  (cor_sin),
		.out_cos  (cor_cos)
	);

	rcp_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cor_valid),
		.in_item  (cor_item),
		.in_sin   (cor_sin),
		.in_cos   (cor_cos),
		.out_valid(mat_valid),
		.out_item (mat_item),
		.out_rmat (mat_rmat)
	);

	rcp_corner #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_corner (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (mat_valid),
		.in_item     (mat_item),
		.in_rmat     (mat_rmat),
		.strobe      (strobe),
		.corner_index(corner_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.last_corner (last_corner)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after a transaction");

	a_last_is_three: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_corner |-> corner_index == 2'd3)
		else $error("last_corner on a corner other than three");

	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && corner_index != 2'd0 |-> $past(strobe) &&
			$past(corner_index) == corner_index - 2'd1)
		else $error("corner results out of order");
`endif

endmodule
